// ----- rtl/qrs_pkg.sv -----
// Shared widths, status codes and sideband type for the quadratic root solver.
package qrs_pkg;

    localparam int W       = 32;
    localparam int F       = 16;
    localparam int DW      = 2 * W + 2;
    localparam int SW      = W + 1;
    localparam int NBW     = W + 1;
    localparam int NSW     = W + 3;
    localparam int NMW     = W + 2;
    localparam int NW      = NMW + F;
    localparam int DENW    = W + 1;
    localparam int DIV_LAT = NW + 1;
    localparam int LAT     = 3 + SW + 2 + DIV_LAT + 1;

    localparam logic [1:0] ST_NONE = 2'd0;
    localparam logic [1:0] ST_ONE  = 2'd1;
    localparam logic [1:0] ST_TWO  = 2'd2;
    localparam logic [1:0] ST_NOTQ = 2'd3;

    typedef struct packed {
        logic [1:0]            status;
        logic signed [NBW-1:0] nb;
        logic [W-1:0]          am;
        logic                  aneg;
    } qrs_side_t;

endpackage

// ----- rtl/qrs_sqrt.sv -----
// Pipelined integer square root, one result bit per stage, with sideband.
module qrs_sqrt (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [qrs_pkg::DW-1:0] in_rad,
    input  qrs_pkg::qrs_side_t  in_side,
    output logic                out_valid,
    output logic [qrs_pkg::SW-1:0] out_root,
    output qrs_pkg::qrs_side_t  out_side
);
    import qrs_pkg::*;

    logic            vld_reg  [0:SW];
    logic [DW-1:0]   rem_reg  [0:SW];
    logic [SW-1:0]   root_reg [0:SW];
    qrs_side_t       side_reg [0:SW];

    assign vld_reg[0]  = in_valid;
    assign rem_reg[0]  = in_rad;
    assign root_reg[0] = '0;
    assign side_reg[0] = in_side;

    for (genvar k = 0; k < SW; k++) begin : g_stage
        localparam int I = W - k;
        logic [DW-1:0] trial;
        logic          ge;

        assign trial = (DW'(root_reg[k]) << (I + 1)) | (DW'(1) << (2 * I));
        assign ge    = rem_reg[k] >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k+1] <= 1'b0;
            end
            else
            begin
                vld_reg[k+1] <= vld_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k+1]  <= ge ? rem_reg[k] - trial : rem_reg[k];
            root_reg[k+1] <= ge ? (root_reg[k] | (SW'(1) << I)) : root_reg[k];
            side_reg[k+1] <= side_reg[k];
        end
    end

    assign out_valid = vld_reg[SW];
    assign out_root  = root_reg[SW];
    assign out_side  = side_reg[SW];

endmodule

// ----- rtl/qrs_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, with signed saturation.
module qrs_div (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic [qrs_pkg::NW-1:0]   in_num,
    input  logic [qrs_pkg::DENW-1:0] in_den,
    input  logic                   in_neg,
    output logic                   out_valid,
    output logic [qrs_pkg::W-1:0]    out_root,
    output logic                   out_sat
);
    import qrs_pkg::*;

    logic            vld_reg [0:NW];
    logic [NW-1:0]   num_reg [0:NW];
    logic [DENW-1:0] den_reg [0:NW];
    logic            neg_reg [0:NW];
    logic [DENW-1:0] rem_reg [0:NW];
    logic [NW-1:0]   q_reg   [0:NW];

    assign vld_reg[0] = in_valid;
    assign num_reg[0] = in_num;
    assign den_reg[0] = in_den;
    assign neg_reg[0] = in_neg;
    assign rem_reg[0] = '0;
    assign q_reg[0]   = '0;

    for (genvar k = 0; k < NW; k++) begin : g_stage
        localparam int I = NW - 1 - k;
        logic [DENW:0] shifted;
        logic [DENW:0] diff;
        logic          ge;

        assign shifted = {rem_reg[k], num_reg[k][I]};
        assign diff    = shifted - {1'b0, den_reg[k]};
        assign ge      = shifted >= {1'b0, den_reg[k]};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k+1] <= 1'b0;
            end
            else
            begin
                vld_reg[k+1] <= vld_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            num_reg[k+1] <= num_reg[k];
            den_reg[k+1] <= den_reg[k];
            neg_reg[k+1] <= neg_reg[k];
            rem_reg[k+1] <= ge ? diff[DENW-1:0] : shifted[DENW-1:0];
            q_reg[k+1]   <= ge ? (q_reg[k] | (NW'(1) << I)) : q_reg[k];
        end
    end

    logic [NW-1:0] lim;
    logic          sat;
    logic [NW-1:0] mag;
    logic          valid_reg;
    logic [W-1:0]  root_reg;
    logic          sat_reg;

    assign lim = (NW'(1) << (W - 1)) - {{(NW-1){1'b0}}, ~neg_reg[NW]};
    assign sat = q_reg[NW] > lim;
    assign mag = sat ? lim : q_reg[NW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= vld_reg[NW];
        end
    end

    always_ff @(posedge clk)
    begin
        root_reg <= neg_reg[NW] ? (~mag[W-1:0] + W'(1)) : mag[W-1:0];
        sat_reg  <= sat;
    end

    assign out_valid = valid_reg;
    assign out_root  = root_reg;
    assign out_sat   = sat_reg;

endmodule

// ----- rtl/quadratic_root_solver.sv -----
// Quadratic root solver top level: discriminant, square root and two root dividers.
// Fully pipelined: one coefficient word may be started every cycle and busy stays low.
// Each word leaves with done after 3 front stages, 33 square root stages,
// 2 numerator stages, 51 divider stages and 1 output stage; the receiver
// must take every result in the cycle it is shown.
module quadratic_root_solver (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic signed [qrs_pkg::W-1:0] coeff_a,
    input  logic signed [qrs_pkg::W-1:0] coeff_b,
    input  logic signed [qrs_pkg::W-1:0] coeff_c,
    output logic                        done,
    output logic [1:0]                  root_status,
    output logic signed [qrs_pkg::W-1:0] root_plus,
    output logic signed [qrs_pkg::W-1:0] root_minus,
    output logic                        saturated
);
    import qrs_pkg::*;

    assign busy = 1'b0;

    logic [W-1:0] a_u, b_u, c_u;
    assign a_u = coeff_a;
    assign b_u = coeff_b;
    assign c_u = coeff_c;

    logic         v1_reg;
    logic [W-1:0] am1_reg, bm1_reg, cm1_reg;
    logic         an1_reg, bn1_reg, cn1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start & ~busy;
        end
    end

    always_ff @(posedge clk)
    begin
        am1_reg <= a_u[W-1] ? (~a_u + W'(1)) : a_u;
        bm1_reg <= b_u[W-1] ? (~b_u + W'(1)) : b_u;
        cm1_reg <= c_u[W-1] ? (~c_u + W'(1)) : c_u;
        an1_reg <= a_u[W-1];
        bn1_reg <= b_u[W-1];
        cn1_reg <= c_u[W-1];
    end

    logic                  v2_reg;
    logic [2*W-1:0]        bsq2_reg, ac2_reg;
    logic [W-1:0]          am2_reg;
    logic                  an2_reg, addp2_reg, az2_reg;
    logic signed [NBW-1:0] nb2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        bsq2_reg  <= bm1_reg * bm1_reg;
        ac2_reg   <= am1_reg * cm1_reg;
        am2_reg   <= am1_reg;
        an2_reg   <= an1_reg;
        az2_reg   <= am1_reg == '0;
        addp2_reg <= (an1_reg != cn1_reg) && (cm1_reg != '0);
        nb2_reg   <= bn1_reg ? {1'b0, bm1_reg} : (~{1'b0, bm1_reg} + NBW'(1));
    end

    logic [DW-1:0] bsqx, fac;
    assign bsqx = DW'(bsq2_reg);
    assign fac  = {ac2_reg, 2'b00};

    logic          v3_reg;
    logic [DW-1:0] d3_reg;
    qrs_side_t     side3_reg;
    logic [1:0]    st3;

    always_comb
    begin
        if (az2_reg)
            st3 = ST_NOTQ;
        else if (addp2_reg)
            st3 = ST_TWO;
        else if (bsqx < fac)
            st3 = ST_NONE;
        else if (bsqx == fac)
            st3 = ST_ONE;
        else
            st3 = ST_TWO;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else
        begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        d3_reg           <= addp2_reg ? (bsqx + fac) : (bsqx - fac);
        side3_reg.status <= st3;
        side3_reg.nb     <= nb2_reg;
        side3_reg.am     <= am2_reg;
        side3_reg.aneg   <= an2_reg;
    end

    logic          sq_valid;
    logic [SW-1:0] sq_root;
    qrs_side_t     sq_side;

    qrs_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v3_reg),
        .in_rad    (d3_reg),
        .in_side   (side3_reg),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_side  (sq_side)
    );

    logic                  v4_reg;
    logic signed [NSW-1:0] np4_reg, nm4_reg;
    logic [W-1:0]          am4_reg;
    logic                  an4_reg;
    logic [1:0]            st4_reg;
    logic [NSW-1:0]        nbx, sx;

    assign nbx = {{(NSW-NBW){sq_side.nb[NBW-1]}}, sq_side.nb};
    assign sx  = {{(NSW-SW){1'b0}}, sq_root};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
        end
        else
        begin
            v4_reg <= sq_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        np4_reg <= nbx + sx;
        nm4_reg <= nbx - sx;
        am4_reg <= sq_side.am;
        an4_reg <= sq_side.aneg;
        st4_reg <= sq_side.status;
    end

    logic             v5_reg;
    logic [NW-1:0]    np5_reg, nm5_reg;
    logic             pn5_reg, mn5_reg;
    logic [DENW-1:0]  den5_reg;
    logic [1:0]       st5_reg;
    logic [NSW-1:0]   pmag, mmag;

    assign pmag = np4_reg[NSW-1] ? (~np4_reg + NSW'(1)) : np4_reg;
    assign mmag = nm4_reg[NSW-1] ? (~nm4_reg + NSW'(1)) : nm4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v5_reg <= 1'b0;
        end
        else
        begin
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        np5_reg  <= {pmag[NMW-1:0], {F{1'b0}}};
        nm5_reg  <= {mmag[NMW-1:0], {F{1'b0}}};
        pn5_reg  <= np4_reg[NSW-1] ^ an4_reg;
        mn5_reg  <= nm4_reg[NSW-1] ^ an4_reg;
        den5_reg <= {am4_reg, 1'b0};
        st5_reg  <= st4_reg;
    end

    logic         dp_valid, dm_valid;
    logic [W-1:0] dp_root, dm_root;
    logic         dp_sat, dm_sat;

    qrs_div u_div_plus (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v5_reg),
        .in_num    (np5_reg),
        .in_den    (den5_reg),
        .in_neg    (pn5_reg),
        .out_valid (dp_valid),
        .out_root  (dp_root),
        .out_sat   (dp_sat)
    );

    qrs_div u_div_minus (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v5_reg),
        .in_num    (nm5_reg),
        .in_den    (den5_reg),
        .in_neg    (mn5_reg),
        .out_valid (dm_valid),
        .out_root  (dm_root),
        .out_sat   (dm_sat)
    );

    logic [1:0] st_dly_reg [0:DIV_LAT];
    assign st_dly_reg[0] = st5_reg;

    for (genvar k = 0; k < DIV_LAT; k++) begin : g_st_dly
        always_ff @(posedge clk)
        begin
            st_dly_reg[k+1] <= st_dly_reg[k];
        end
    end

    logic         done_reg;
    logic [1:0]   status_reg;
    logic [W-1:0] plus_reg, minus_reg;
    logic         sat_reg;
    logic         has_root;

    assign has_root = (st_dly_reg[DIV_LAT] == ST_ONE) || (st_dly_reg[DIV_LAT] == ST_TWO);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= dp_valid & dm_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= st_dly_reg[DIV_LAT];
        plus_reg   <= has_root ? dp_root : '0;
        minus_reg  <= has_root ? dm_root : '0;
        sat_reg    <= has_root & (dp_sat | dm_sat);
    end

    assign done        = done_reg;
    assign root_status = status_reg;
    assign root_plus   = plus_reg;
    assign root_minus  = minus_reg;
    assign saturated   = sat_reg;

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("result word missing after fixed latency");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |-> ##LAT !done)
        else $error("result word without a started word");

    a_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        dp_valid == dm_valid)
        else $error("divider lanes out of step");

    a_one_root: assert property (@(posedge clk) disable iff (!rst_n)
        (done && root_status == ST_ONE) |-> (root_plus == root_minus))
        else $error("single root differs between lanes");

    a_no_root_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (root_status == ST_NONE || root_status == ST_NOTQ))
            |-> (root_plus == '0 && root_minus == '0 && !saturated))
        else $error("roots reported without real roots");

endmodule

// ----- verif/qrs_root_checker.sv -----
// Root prediction and result comparison for the quadratic root solver.
module qrs_root_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic                         busy,
    input  logic signed [qrs_pkg::W-1:0] coeff_a,
    input  logic signed [qrs_pkg::W-1:0] coeff_b,
    input  logic signed [qrs_pkg::W-1:0] coeff_c,
    input  logic                         done,
    input  logic [1:0]                   root_status,
    input  logic signed [qrs_pkg::W-1:0] root_plus,
    input  logic signed [qrs_pkg::W-1:0] root_minus,
    input  logic                         saturated,
    output int                           fail_count,
    output int                           pending_roots,
    output int                           roots_seen,
    output int                           sat_seen
);
    timeunit 1ns;
    timeprecision 1ps;
    import qrs_pkg::*;

    typedef struct packed {
        logic [1:0]          status;
        logic signed [W-1:0] plus;
        logic signed [W-1:0] minus;
        logic                sat;
    } roots_t;

    roots_t expected_roots[$];

    function automatic logic signed [W-1:0] scaled_quotient(
        input logic signed [W+3:0] num, input logic signed [W:0] a_val, inout logic sat);
        logic signed [127:0] q;
        logic signed [127:0] hi_lim;
        logic signed [127:0] lo_lim;
        hi_lim = (128'sd1 <<< (W - 1)) - 1;
        lo_lim = -(128'sd1 <<< (W - 1));
        q = (128'(num) <<< F) / (128'(a_val) * 2);
        if (q > hi_lim)
        begin
            sat = 1'b1;
            q = hi_lim;
        end
        else if (q < lo_lim)
        begin
            sat = 1'b1;
            q = lo_lim;
        end
        return q[W-1:0];
    endfunction

    function automatic roots_t solve_roots(input logic signed [W-1:0] a,
        input logic signed [W-1:0] b, input logic signed [W-1:0] c);
        roots_t r;
        logic signed [127:0] disc;
        logic [127:0] s;
        logic [127:0] cand;
        logic sat;
        r = '0;
        sat = 1'b0;
        if (a == 0)
        begin
            r.status = ST_NOTQ;
            return r;
        end
        disc = 128'(b) * 128'(b) - 128'sd4 * 128'(a) * 128'(c);
        if (disc < 0)
        begin
            r.status = ST_NONE;
            return r;
        end
        if (disc == 0)
        begin
            r.status = ST_ONE;
            r.plus = scaled_quotient(-(W+4)'(b), (W+1)'(a), sat);
            r.minus = r.plus;
        end
        else
        begin
            s = 0;
            for (int i = W; i >= 0; i--)
            begin
                cand = s | (128'd1 << i);
                if (cand * cand <= 128'(disc))
                    s = cand;
            end
            r.status = ST_TWO;
            r.plus = scaled_quotient(-(W+4)'(b) + (W+4)'(s), (W+1)'(a), sat);
            r.minus = scaled_quotient(-(W+4)'(b) - (W+4)'(s), (W+1)'(a), sat);
        end
        r.sat = sat;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [W-1:0] got,
        input logic [W-1:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    initial
    begin
        fail_count = 0;
        pending_roots = 0;
        roots_seen = 0;
        sat_seen = 0;
    end

    always @(posedge clk)
    begin
        roots_t want;
        if (rst_n && start && !busy)
            expected_roots.push_back(solve_roots(coeff_a, coeff_b, coeff_c));
        if (rst_n && done)
        begin
            if (expected_roots.size() == 0)
            begin
                $display("unexpected result word at %0t", $realtime);
                fail_count++;
            end
            else
            begin
                want = expected_roots.pop_front();
                roots_seen++;
                if (want.sat)
                    sat_seen++;
                if (root_status != want.status)
                    report_mismatch("root_status", W'(root_status), W'(want.status));
                if (root_plus != want.plus)
                    report_mismatch("root_plus", root_plus, want.plus);
                if (root_minus != want.minus)
                    report_mismatch("root_minus", root_minus, want.minus);
                if (saturated != want.sat)
                    report_mismatch("saturated", W'(saturated), W'(want.sat));
            end
        end
        pending_roots = expected_roots.size();
    end
endmodule

// ----- verif/tb_quadratic_root_solver.sv -----
// Stimulus, clock, reset and verdict for the quadratic root solver.
module tb_quadratic_root_solver;
    timeunit 1ns;
    timeprecision 1ps;
    import qrs_pkg::*;

    localparam int RANDOM_WORDS = 1500;
    localparam int WATCHDOG_LIMIT = 4 * LAT + 200;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic signed [W-1:0] coeff_a = '0;
    logic signed [W-1:0] coeff_b = '0;
    logic signed [W-1:0] coeff_c = '0;
    logic done;
    logic [1:0] root_status;
    logic signed [W-1:0] root_plus;
    logic signed [W-1:0] root_minus;
    logic saturated;
    int fail_count;
    int pending_roots;
    int roots_seen;
    int sat_seen;
    int quiet_cycles = 0;
    int words_sent = 0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    quadratic_root_solver DUT (.*);
    qrs_root_checker u_checker (.*);

    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > WATCHDOG_LIMIT)
        begin
            $display("watchdog expired");
            $display("simulation failed");
            $finish;
        end
    end

    task automatic send_word(input logic [W-1:0] a, input logic [W-1:0] b,
        input logic [W-1:0] c, input bit may_idle);
        while (may_idle && $urandom_range(99) < 17)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        coeff_a <= a;
        coeff_b <= b;
        coeff_c <= c;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        words_sent++;
    endtask

    function automatic logic [W-1:0] pick_coeff();
        case ($urandom_range(5))
            0: return $urandom;
            1: return W'($signed($urandom_range(8 << F)) - $signed(4 << F));
            2: return W'($urandom_range(7)) << $urandom_range(W - 1);
            3: return -(W'($urandom_range(7)) << $urandom_range(W - 1));
            4: return $urandom & 32'h0003_ffff;
            default: return $urandom_range(3) == 0 ? 32'h8000_0000 : 32'h7fff_ffff;
        endcase
    endfunction

    initial
    begin
        logic [W-1:0] r;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_word('0, 32'h0001_0000, 32'h0002_0000, 1'b0);
        send_word(32'h0001_0000, '0, 32'h0001_0000, 1'b0);
        send_word(32'h0001_0000, 32'hfffe_0000, 32'h0001_0000, 1'b0);
        send_word(32'h0001_0000, '0, 32'hfffc_0000, 1'b0);
        send_word(32'h0001_0000, 32'hfffd_0000, 32'h0002_0000, 1'b0);
        send_word(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
        send_word(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0);
        send_word(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0);
        send_word(32'h0000_0001, 32'h7fff_ffff, '0, 1'b0);
        send_word(32'h0000_0001, 32'h8000_0000, 32'h8000_0000, 1'b0);
        send_word(32'hffff_ffff, 32'h8000_0000, '0, 1'b0);
        send_word(32'h0000_0001, 32'h0000_0002, 32'h0000_0001, 1'b0);
        send_word(32'hffff_0000, 32'h0003_0000, 32'h7fff_ffff, 1'b0);
        send_word(32'h7fff_ffff, '0, 32'h8000_0000, 1'b0);
        send_word(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1'b0);
        start <= 1'b0;
        while (pending_roots != 0)
            @(posedge clk);
        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            if ($urandom_range(9) < 2)
            begin
                r = W'($signed($urandom_range(64)) - 32);
                send_word(W'(1) << F, -(r << (F + 1)), (r * r) << F,
                          !(i >= 600 && i < 800));
            end
            else
                send_word(pick_coeff(), pick_coeff(), pick_coeff(),
                          !(i >= 600 && i < 800));
        end
        start <= 1'b0;
        while (pending_roots != 0)
            @(posedge clk);
        repeat (LAT + 10) @(posedge clk);
        $display("%0d coefficient words sent, %0d result words checked, %0d saturated",
                 words_sent, roots_seen, sat_seen);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule

// ----- sim.f -----
rtl/qrs_pkg.sv
rtl/qrs_sqrt.sv
rtl/qrs_div.sv
rtl/quadratic_root_solver.sv
verif/qrs_root_checker.sv
verif/tb_quadratic_root_solver.sv
